>>> sv/max_sum_path_two_sorted_assert.svh
`ifndef MAX_SUM_PATH_TWO_SORTED_ASSERT_SVH
`define MAX_SUM_PATH_TWO_SORTED_ASSERT_SVH

// Checks that hold in the same cycle as the antecedent.
`define MSP_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Checks that hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> sv/msp_pkg.sv
package msp_pkg;

	localparam int unsigned DEPTH_DEF = 1024;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned PSUM_W = 48;

	localparam logic [1:0] FN_APPEND_A = 2'd0;
	localparam logic [1:0] FN_APPEND_B = 2'd1;
	localparam logic [1:0] FN_COMPUTE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MERGE,
		ST_RFETCH,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic start;
		logic rd;
		logic adv_a;
		logic adv_b;
		logic match;
		logic close;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic i_lt_m;
		logic j_lt_n;
		logic a_lt_b;
		logic a_gt_b;
		logic a_eq_c;
		logic b_eq_c;
		logic out_busy;
	} sts_t;

endpackage

>>> sv/max_sum_path_two_sorted.sv
// Maximum sum path through two ascending sorted arrays. A request with func 0
// or 1 appends value to the first or second store and is taken without a
// stall; an append to a full store is dropped and reported with the next
// result. A request with func 2 walks both stores as a merge and returns one
// result with the path sum and the drop flag, then empties both stores.
// The walk reads each store through one registered read port, so each step
// has a read state before its compare state. A compute request keeps the
// input stalled for the whole walk, plus any wait for an earlier result to
// leave the output. A step inside an equal run consumes one element from each
// store whose next element still equals the common value. Appends are taken
// while an earlier result still waits at the output. The stores need no
// clearing after reset.
module max_sum_path_two_sorted import msp_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [PSUM_W-1:0] path_sum,
	output logic                     overflowed
);

	cmd_t cmd;
	sts_t sts;

	msp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	msp_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.out_stall  (out_stall),
		.sts        (sts),
		.out_valid  (out_valid),
		.path_sum   (path_sum),
		.overflowed (overflowed)
	);

endmodule

>>> sv/msp_ctrl.sv
module msp_ctrl import msp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] func,
	input  sts_t       sts,
	output logic       in_stall,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (func)
						FN_APPEND_A: cmd.load_a = 1'b1;
						FN_APPEND_B: cmd.load_b = 1'b1;
						FN_COMPUTE: begin
							cmd.start = 1'b1;
							state_d = ST_FETCH;
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.rd = 1'b1;
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (sts.i_lt_m && sts.j_lt_n) begin
					if (sts.a_lt_b) begin
						cmd.adv_a = 1'b1;
						state_d = ST_FETCH;
					end else if (sts.a_gt_b) begin
						cmd.adv_b = 1'b1;
						state_d = ST_FETCH;
					end else begin
						cmd.match = 1'b1;
						state_d = ST_RFETCH;
					end
				end else if (sts.i_lt_m) begin
					cmd.adv_a = 1'b1;
					state_d = ST_FETCH;
				end else if (sts.j_lt_n) begin
					cmd.adv_b = 1'b1;
					state_d = ST_FETCH;
				end else begin
					cmd.close = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_RFETCH: begin
				cmd.rd = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.adv_a = sts.i_lt_m && sts.a_eq_c;
				cmd.adv_b = sts.j_lt_n && sts.b_eq_c;
				if (cmd.adv_a || cmd.adv_b) begin
					state_d = ST_RFETCH;
				end else begin
					cmd.close = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> sv/msp_dp.sv
module msp_dp import msp_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic signed [VAL_W-1:0]  value,
	input  logic                     out_stall,
	output sts_t                     sts,
	output logic                     out_valid,
	output logic signed [PSUM_W-1:0] path_sum,
	output logic                     overflowed
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = VAL_W + CW;
	localparam int unsigned XW = (SW > PSUM_W) ? SW : PSUM_W;

	logic signed [VAL_W-1:0] mem_a [DEPTH];
	logic signed [VAL_W-1:0] mem_b [DEPTH];

	logic [CW-1:0] cnt_a_q;
	logic [CW-1:0] cnt_b_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic          drop_q;
	logic          full_a;
	logic          full_b;

	logic signed [VAL_W-1:0]  a_q;
	logic signed [VAL_W-1:0]  b_q;
	logic signed [VAL_W-1:0]  com_q;
	logic signed [SW-1:0]     s1_q;
	logic signed [SW-1:0]     s2_q;
	logic signed [PSUM_W-1:0] tot_q;
	logic signed [SW-1:0]     a_ext;
	logic signed [SW-1:0]     b_ext;
	logic signed [SW-1:0]     mx;
	logic signed [XW-1:0]     mx_x;

	assign full_a = (cnt_a_q == CW'(DEPTH));
	assign full_b = (cnt_b_q == CW'(DEPTH));
	assign a_ext = SW'(a_q);
	assign b_ext = SW'(b_q);
	assign mx = (s1_q > s2_q) ? s1_q : s2_q;
	assign mx_x = XW'(mx);

	assign sts.i_lt_m = (i_q < cnt_a_q);
	assign sts.j_lt_n = (j_q < cnt_b_q);
	assign sts.a_lt_b = (a_q < b_q);
	assign sts.a_gt_b = (a_q > b_q);
	assign sts.a_eq_c = (a_q == com_q);
	assign sts.b_eq_c = (b_q == com_q);
	assign sts.out_busy = out_valid && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load_a && !full_a) begin
			mem_a[cnt_a_q[AW-1:0]] <= value;
		end
		if (cmd.rd && sts.i_lt_m) begin
			a_q <= mem_a[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_b && !full_b) begin
			mem_b[cnt_b_q[AW-1:0]] <= value;
		end
		if (cmd.rd && sts.j_lt_n) begin
			b_q <= mem_b[j_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load_a) begin
				if (full_a) begin
					drop_q <= 1'b1;
				end else begin
					cnt_a_q <= cnt_a_q + CW'(1);
				end
			end
			if (cmd.load_b) begin
				if (full_b) begin
					drop_q <= 1'b1;
				end else begin
					cnt_b_q <= cnt_b_q + CW'(1);
				end
			end
			if (cmd.start) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (cmd.adv_a || cmd.match) begin
					i_q <= i_q + CW'(1);
				end
				if (cmd.adv_b || cmd.match) begin
					j_q <= j_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				drop_q <= 1'b0;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s1_q <= '0;
			s2_q <= '0;
			tot_q <= '0;
		end else if (cmd.match) begin
			tot_q <= tot_q + mx_x[PSUM_W-1:0];
			s1_q <= a_ext;
			s2_q <= b_ext;
			com_q <= a_q;
		end else if (cmd.close) begin
			tot_q <= tot_q + mx_x[PSUM_W-1:0];
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			if (cmd.adv_a) begin
				s1_q <= s1_q + a_ext;
			end
			if (cmd.adv_b) begin
				s2_q <= s2_q + b_ext;
			end
		end
		if (cmd.emit) begin
			path_sum <= tot_q;
			overflowed <= drop_q;
		end
	end

endmodule

>>> sv/max_sum_path_two_sorted_chk.sv
`include "max_sum_path_two_sorted_assert.svh"

module max_sum_path_two_sorted_chk import msp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [1:0]               func,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [PSUM_W-1:0] path_sum,
	input logic                     overflowed
);

	// A stalled result must hold.
	`MSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(path_sum) && $stable(overflowed), "stalled result changed")

	// A compute request starts the walk, so the input stalls in the next cycle.
	`MSP_ASSERT_NEXT(a_walk_stalls, in_valid && !in_stall && func == FN_COMPUTE, in_stall, "input not stalled during walk")

	// A new result only appears at the end of a walk.
	`MSP_ASSERT_SAME(a_result_after_walk, $rose(out_valid), $past(in_stall), "result without walk")

	// Appends and unused codes never produce a result.
	`MSP_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && func != FN_COMPUTE && !out_valid, !out_valid, "result from non-compute request")

endmodule

bind max_sum_path_two_sorted max_sum_path_two_sorted_chk u_chk (.*);
